@@ sv/cdeq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdeq_pkg
// Shared codes and constants for the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdeq_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_PUSH_FRONT = 2'd0;
  localparam mode_t MODE_PUSH_REAR  = 2'd1;
  localparam mode_t MODE_POP_FRONT  = 2'd2;
  localparam mode_t MODE_POP_REAR   = 2'd3;

  // APB side
  localparam int PDATA_W = 32;
  localparam int ADDR_W  = 3;

  typedef logic [ADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_CAPACITY = 1'b0;

  // capacity register
  localparam int         CAP_W     = 7;
  localparam [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage

@@ sv/cdeq_ram.sv @@
// ----------------------------------------------------------------------------
// cdeq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module cdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                      rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                      rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ sv/circular_double_ended_queue_core.sv @@
// ----------------------------------------------------------------------------
// circular_double_ended_queue_core
// Ring-buffer deque: push/pop at either end, run-time capacity over APB.
// ----------------------------------------------------------------------------
// done pulses in the cycle after start.
// Throughput: one operation per cycle; busy stays low and done cannot be held.
// The ends and their neighbours sit in registers; the next-but-one entries
// at each end are prefetched from the two-read-port ring RAM every cycle.
// Reset: synchronous; deque empty, capacity 64, RAM contents left as they are.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_core
  import cdeq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // command side
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic signed [DATA_WIDTH-1:0] value,
  // result side
  output logic                         done,
  output logic                         ok,
  output logic signed [DATA_WIDTH-1:0] popped,
  output logic                         is_empty,
  output logic                         is_full,
  output logic signed [DATA_WIDTH-1:0] front_value,
  output logic signed [DATA_WIDTH-1:0] rear_value,
  // APB
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]           pwdata,
  output logic [PDATA_W-1:0]           prdata,
  output logic                         pready
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  // ---------------------------------------------------------------------------
  // registers
  logic [CAP_W-1:0] capacity;
  idx_t  head, head_next;
  idx_t  tail, tail_next;
  cnt_t  count, count_next;
  word_t front, front_next;     // entry at head
  word_t rear, rear_next;       // entry at tail
  word_t front2, front2_next;   // entry at head+1
  word_t rear2, rear2_next;     // entry at tail-1

  cnt_t  cap_eff;
  logic  cfg_wr;

  logic  ram_we;
  idx_t  ram_waddr;
  word_t ram_wdata;
  idx_t  raddr_a, raddr_b;
  word_t front3, rear3;         // prefetched head+2 / tail-2

  logic  ok_next;
  word_t popped_next;
  logic  is_full_next;

  // ---------------------------------------------------------------------------
  function automatic idx_t idx_inc(input idx_t x, input cnt_t c);
    idx_t r;
    if (CNT_W'(x) == c - 1'b1) r = '0;
    else                        r = x + 1'b1;
    return r;
  endfunction

  function automatic idx_t idx_dec(input idx_t x, input cnt_t c);
    idx_t r;
    if (x == '0) r = IDX_W'(c - 1'b1);
    else         r = x - 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // APB
  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1:2] == REG_CAPACITY);

  always_comb begin
    if (paddr[ADDR_W-1:2] == REG_CAPACITY) prdata = {{(PDATA_W-CAP_W){1'b0}}, capacity};
    else                                   prdata = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // saturate the register into 1..DEPTH
  always_comb begin
    if (int'(capacity) > DEPTH) cap_eff = CNT_W'(DEPTH);
    else if (capacity == '0)     cap_eff = CNT_W'(1);
    else                         cap_eff = CNT_W'(capacity);
  end

  // ---------------------------------------------------------------------------
  // operation
  always_comb begin
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    front_next   = front;
    rear_next    = rear;
    front2_next  = front2;
    rear2_next   = rear2;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = value;
    ok_next      = 1'b0;
    popped_next  = '1;

    if (cfg_wr) begin
      head_next  = '0;
      tail_next  = '0;
      count_next = '0;
    end else if (start) begin
      unique case (mode)
        MODE_PUSH_FRONT: begin
          if (count != cap_eff) begin
            ok_next    = 1'b1;
            ram_we     = 1'b1;
            count_next = count + 1'b1;
            front_next = value;
            if (count == '0) begin
              head_next = '0;
              tail_next = '0;
              rear_next = value;
            end else begin
              head_next   = idx_dec(head, cap_eff);
              front2_next = front;
              if (count == CNT_W'(1)) rear2_next = value;
            end
            ram_waddr = head_next;
          end
        end
        MODE_PUSH_REAR: begin
          if (count != cap_eff) begin
            ok_next    = 1'b1;
            ram_we     = 1'b1;
            count_next = count + 1'b1;
            rear_next  = value;
            if (count == '0) begin
              head_next  = '0;
              tail_next  = '0;
              front_next = value;
            end else begin
              tail_next  = idx_inc(tail, cap_eff);
              rear2_next = rear;
              if (count == CNT_W'(1)) front2_next = value;
            end
            ram_waddr = tail_next;
          end
        end
        MODE_POP_FRONT: begin
          if (count != '0) begin
            ok_next     = 1'b1;
            popped_next = front;
            count_next  = count - 1'b1;
            if (count == CNT_W'(1)) begin
              head_next = '0;
              tail_next = '0;
            end else begin
              head_next  = idx_inc(head, cap_eff);
              front_next = front2;
              if (count == CNT_W'(3)) front2_next = rear;
              else                    front2_next = front3;
            end
          end
        end
        MODE_POP_REAR: begin
          if (count != '0) begin
            ok_next     = 1'b1;
            popped_next = rear;
            count_next  = count - 1'b1;
            if (count == CNT_W'(1)) begin
              head_next = '0;
              tail_next = '0;
            end else begin
              tail_next = idx_dec(tail, cap_eff);
              rear_next = rear2;
              if (count == CNT_W'(3)) rear2_next = front;
              else                    rear2_next = rear3;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign is_full_next = (count_next == cap_eff) && !cfg_wr;

  // prefetch for the next cycle. A same-cycle write never hits these
  // addresses while the prefetched word is needed (four or more entries).
  assign raddr_a = idx_inc(idx_inc(head_next, cap_eff), cap_eff);
  assign raddr_b = idx_dec(idx_dec(tail_next, cap_eff), cap_eff);

  cdeq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (front3),
    .raddr_b (raddr_b),
    .rdata_b (rear3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      done  <= start && !busy;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    front  <= front_next;
    rear   <= rear_next;
    front2 <= front2_next;
    rear2  <= rear2_next;
    if (start) begin
      ok          <= ok_next;
      popped      <= popped_next;
      is_empty    <= (count_next == '0);
      is_full     <= is_full_next;
      front_value <= (count_next == '0) ? '1 : front_next;
      rear_value  <= (count_next == '0) ? '1 : rear_next;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= cap_eff)
    else $error("entry count above capacity");

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("no result beat after accepted command");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !start |=> !done)
    else $error("result beat without command");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (rst)
    done && !ok && !$past(cfg_wr) && !$past(rst) |-> count == $past(count))
    else $error("rejected operation changed the deque");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_empty && is_full))
    else $error("empty and full together");

endmodule
